// ----- sv/bpc_pkg.sv -----
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared types, constants and helpers for the pressure compensation pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package bpc_pkg;

    typedef struct packed {
        logic [15:0] raw_temp;
        logic [15:0] raw_press;
    } req_t;

    typedef struct packed {
        logic signed [31:0] temp_tenths;
        logic signed [31:0] press_pa;
        logic               div_fault;
    } res_t;

    typedef struct packed {
        logic [31:0] cal_word_a;
        logic [31:0] cal_word_b;
        logic [31:0] cal_word_c;
        logic [31:0] cal_word_d;
        logic [31:0] cal_word_e;
    } cal_t;

    typedef enum logic [2:0] {
        REG_CAL_A = 3'd0,
        REG_CAL_B = 3'd1,
        REG_CAL_C = 3'd2,
        REG_CAL_D = 3'd3,
        REG_CAL_E = 3'd4
    } reg_idx_t;

    localparam int DIV_STAGES = 32;
    localparam int SIDE_W     = 64;
    localparam int TEMP_LAT   = 4 + DIV_STAGES + 1;
    localparam int PRESS_LAT  = 7 + DIV_STAGES + 5;

    // Signed division by 2**k with truncation toward zero.
    function automatic logic signed [31:0] sdiv_pow2(input logic signed [31:0] v,
                                                     input int unsigned k);
        logic signed [31:0] bias;
        bias = v[31] ? ((32'sd1 <<< k) - 32'sd1) : 32'sd0;
        return (v + bias) >>> k;
    endfunction

    function automatic logic signed [31:0] sext16(input logic [15:0] h);
        return {{16{h[15]}}, h};
    endfunction

endpackage

`default_nettype wire

// ----- sv/bpc_udiv.sv -----
// ----------------------------------------------------------------------------
// bpc_udiv
// Pipelined unsigned 32-bit divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module bpc_udiv (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        valid,
    input  wire logic [31:0]                 dividend,
    input  wire logic [31:0]                 divisor,
    input  wire logic [bpc_pkg::SIDE_W-1:0]  side,
    output logic                             q_valid,
    output logic [31:0]                      quotient,
    output logic [bpc_pkg::SIDE_W-1:0]       q_side
);

    logic                        vld_reg  [bpc_pkg::DIV_STAGES];
    logic [31:0]                 rem_reg  [bpc_pkg::DIV_STAGES];
    logic [31:0]                 dq_reg   [bpc_pkg::DIV_STAGES];
    logic [31:0]                 dvs_reg  [bpc_pkg::DIV_STAGES];
    logic [bpc_pkg::SIDE_W-1:0]  side_reg [bpc_pkg::DIV_STAGES];

    // Restoring step: remainder and the dividend/quotient shift word together.
    function automatic logic [63:0] step(input logic [31:0] rem, input logic [31:0] dq,
                                         input logic [31:0] dvs);
        logic [32:0] trial;
        logic [32:0] diff;
        logic [31:0] rem_n;
        logic        qbit;
        trial = {rem, dq[31]};
        diff  = trial - {1'b0, dvs};
        qbit  = ~diff[32];
        rem_n = qbit ? diff[31:0] : trial[31:0];
        return {rem_n, dq[30:0], qbit};
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < bpc_pkg::DIV_STAGES; s++)
            begin
                vld_reg[s] <= 1'b0;
            end
        end
        else
        begin
            vld_reg[0] <= valid;
            for (int s = 1; s < bpc_pkg::DIV_STAGES; s++)
            begin
                vld_reg[s] <= vld_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        {rem_reg[0], dq_reg[0]} <= step(32'd0, dividend, divisor);
        dvs_reg[0]  <= divisor;
        side_reg[0] <= side;
        for (int s = 1; s < bpc_pkg::DIV_STAGES; s++)
        begin
            {rem_reg[s], dq_reg[s]} <= step(rem_reg[s-1], dq_reg[s-1], dvs_reg[s-1]);
            dvs_reg[s]  <= dvs_reg[s-1];
            side_reg[s] <= side_reg[s-1];
        end
    end

    assign q_valid  = vld_reg[bpc_pkg::DIV_STAGES-1];
    assign quotient = dq_reg[bpc_pkg::DIV_STAGES-1];
    assign q_side   = side_reg[bpc_pkg::DIV_STAGES-1];

endmodule

`default_nettype wire

// ----- sv/bpc_temp.sv -----
// ----------------------------------------------------------------------------
// bpc_temp
// Temperature front end: computes B5 from the raw temperature reading.
// ----------------------------------------------------------------------------
`default_nettype none

module bpc_temp (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               valid,
    input  wire bpc_pkg::req_t      request,
    input  wire bpc_pkg::cal_t      cal,
    output logic                    b5_valid,
    output logic signed [31:0]      b5,
    output logic [15:0]             up,
    output logic                    fault
);

    logic               v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic signed [16:0] diff_reg;
    logic [15:0]        up1_reg, up2_reg, up3_reg, up4_reg;
    logic signed [31:0] prod_reg;
    logic signed [31:0] x1_3_reg, den_reg, x1_4_reg;
    logic [31:0]        num_mag_reg, den_mag_reg;
    logic               neg_reg, fault4_reg;
    logic signed [31:0] b5_reg;
    logic [15:0]        up5_reg;
    logic               fault5_reg;

    logic signed [31:0] x1_next, den_next, num_s;
    logic               q_valid;
    logic [31:0]        quotient, x2_mag;
    logic [bpc_pkg::SIDE_W-1:0] side_in, q_side;
    logic signed [31:0] x2_s;

    always_comb
    begin
        x1_next = bpc_pkg::sdiv_pow2(prod_reg, 15);
        den_next = x1_next + bpc_pkg::sext16(cal.cal_word_e[15:0]);
        num_s = {{5{cal.cal_word_e[31]}}, cal.cal_word_e[31:16], 11'd0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= q_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        diff_reg    <= $signed({1'b0, request.raw_temp}) - $signed({1'b0, cal.cal_word_c[15:0]});
        up1_reg     <= request.raw_press;
        prod_reg    <= 32'($signed(diff_reg)) * $signed({16'd0, cal.cal_word_c[31:16]});
        up2_reg     <= up1_reg;
        x1_3_reg    <= x1_next;
        den_reg     <= den_next;
        up3_reg     <= up2_reg;
        num_mag_reg <= num_s[31] ? 32'(-num_s) : 32'(num_s);
        den_mag_reg <= den_reg[31] ? 32'(-den_reg) : 32'(den_reg);
        neg_reg     <= num_s[31] ^ den_reg[31];
        fault4_reg  <= (den_reg == 32'sd0);
        x1_4_reg    <= x1_3_reg;
        up4_reg     <= up3_reg;
    end

    assign side_in = {14'd0, neg_reg, fault4_reg, up4_reg, x1_4_reg};

    bpc_udiv u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .valid    (v4_reg),
        .dividend (num_mag_reg),
        .divisor  (den_mag_reg),
        .side     (side_in),
        .q_valid  (q_valid),
        .quotient (quotient),
        .q_side   (q_side)
    );

    assign x2_mag = q_side[49] ? 32'(-quotient) : quotient;
    assign x2_s   = $signed(x2_mag);

    always_ff @(posedge clk)
    begin
        b5_reg     <= $signed(q_side[31:0]) + x2_s;
        up5_reg    <= q_side[47:32];
        fault5_reg <= q_side[48];
    end

    // Stage 4 valid feeds the divider, stage 5 follows it.
    assign b5_valid = v5_reg;
    assign b5       = b5_reg;
    assign up       = up5_reg;
    assign fault    = fault5_reg;

endmodule

`default_nettype wire

// ----- sv/bpc_press.sv -----
// ----------------------------------------------------------------------------
// bpc_press
// Pressure back end: temperature output, B3/B4/B7 and the final correction.
// ----------------------------------------------------------------------------
`default_nettype none

module bpc_press (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               valid,
    input  wire logic signed [31:0] b5,
    input  wire logic [15:0]        up,
    input  wire logic               fault,
    input  wire bpc_pkg::cal_t      cal,
    output logic                    res_valid,
    output bpc_pkg::res_t           res
);

    logic signed [31:0] ac1, ac2, ac3, b1, b2;
    logic [31:0]        ac4;

    logic [6:0]         v_reg;
    logic               v8_reg, v9_reg, v10_reg, v11_reg, v12_reg;

    // Pre-divider stages.
    logic signed [31:0] t1_reg, b6_reg;
    logic [15:0]        up1_reg, up2_reg, up3_reg, up4_reg, up5_reg;
    logic               f1_reg, f2_reg, f3_reg, f4_reg, f5_reg, f6_reg, f7_reg;
    logic signed [31:0] t2_reg, t3_reg, t4_reg, t5_reg, t6_reg, t7_reg;
    logic signed [31:0] sqp_reg, mac2_reg, mac3_reg;
    logic signed [31:0] sq_reg, x2a_reg, x1c_reg;
    logic signed [31:0] mb2_reg, mb1_reg, x2a4_reg, x1c4_reg;
    logic signed [31:0] b3_reg, x3c_reg;
    logic [31:0]        b4p_reg, b7_reg;
    logic [31:0]        num_reg, b4_reg;
    logic               b7hi_reg;

    // Post-divider stages.
    logic signed [31:0] p8_reg, t8_reg;
    logic               f8_reg;
    logic signed [31:0] p9_reg, pd_reg, m7357_reg, t9_reg;
    logic               f9_reg;
    logic signed [31:0] p10_reg, pdsq_reg, x2p_reg, t10_reg;
    logic               f10_reg;
    logic signed [31:0] p11_reg, m3038_reg, x2p11_reg, t11_reg;
    logic               f11_reg;
    bpc_pkg::res_t      res_reg;

    logic signed [31:0] x1a, x3a, x2c;
    logic               q_valid;
    logic [31:0]        quotient;
    logic [bpc_pkg::SIDE_W-1:0] side_in, q_side;
    logic [31:0]        p_u;
    logic signed [31:0] x1p, pf;

    assign ac1 = bpc_pkg::sext16(cal.cal_word_a[31:16]);
    assign ac2 = bpc_pkg::sext16(cal.cal_word_a[15:0]);
    assign ac3 = bpc_pkg::sext16(cal.cal_word_b[31:16]);
    assign ac4 = {16'd0, cal.cal_word_b[15:0]};
    assign b1  = bpc_pkg::sext16(cal.cal_word_d[31:16]);
    assign b2  = bpc_pkg::sext16(cal.cal_word_d[15:0]);

    always_comb
    begin
        x1a = bpc_pkg::sdiv_pow2(mb2_reg, 11);
        x3a = x1a + x2a4_reg;
        x2c = bpc_pkg::sdiv_pow2(mb1_reg, 16);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg   <= '0;
            v8_reg  <= 1'b0;
            v9_reg  <= 1'b0;
            v10_reg <= 1'b0;
            v11_reg <= 1'b0;
            v12_reg <= 1'b0;
        end
        else
        begin
            v_reg   <= {v_reg[5:0], valid};
            v8_reg  <= q_valid;
            v9_reg  <= v8_reg;
            v10_reg <= v9_reg;
            v11_reg <= v10_reg;
            v12_reg <= v11_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        // Stage 1
        t1_reg   <= bpc_pkg::sdiv_pow2(b5 + 32'sd8, 4);
        b6_reg   <= b5 - 32'sd4000;
        up1_reg  <= up;
        f1_reg   <= fault;
        // Stage 2
        sqp_reg  <= b6_reg * b6_reg;
        mac2_reg <= ac2 * b6_reg;
        mac3_reg <= ac3 * b6_reg;
        t2_reg   <= t1_reg;
        up2_reg  <= up1_reg;
        f2_reg   <= f1_reg;
        // Stage 3
        sq_reg   <= bpc_pkg::sdiv_pow2(sqp_reg, 12);
        x2a_reg  <= bpc_pkg::sdiv_pow2(mac2_reg, 11);
        x1c_reg  <= bpc_pkg::sdiv_pow2(mac3_reg, 13);
        t3_reg   <= t2_reg;
        up3_reg  <= up2_reg;
        f3_reg   <= f2_reg;
        // Stage 4
        mb2_reg  <= b2 * sq_reg;
        mb1_reg  <= b1 * sq_reg;
        x2a4_reg <= x2a_reg;
        x1c4_reg <= x1c_reg;
        t4_reg   <= t3_reg;
        up4_reg  <= up3_reg;
        f4_reg   <= f3_reg;
        // Stage 5
        b3_reg   <= bpc_pkg::sdiv_pow2((ac1 <<< 2) + x3a + 32'sd2, 2);
        x3c_reg  <= bpc_pkg::sdiv_pow2(x1c4_reg + x2c + 32'sd2, 2);
        t5_reg   <= t4_reg;
        up5_reg  <= up4_reg;
        f5_reg   <= f4_reg;
        // Stage 6: the B4 and B7 step is unsigned.
        b4p_reg  <= ac4 * (32'(x3c_reg) + 32'd32768);
        b7_reg   <= ({16'd0, up5_reg} - 32'(b3_reg)) * 32'd50000;
        t6_reg   <= t5_reg;
        f6_reg   <= f5_reg;
        // Stage 7
        b4_reg   <= {15'd0, b4p_reg[31:15]};
        b7hi_reg <= b7_reg[31];
        num_reg  <= b7_reg[31] ? b7_reg : {b7_reg[30:0], 1'b0};
        t7_reg   <= t6_reg;
        f7_reg   <= f6_reg | (b4p_reg[31:15] == 17'd0);
    end

    assign side_in = {30'd0, b7hi_reg, f7_reg, t7_reg};

    bpc_udiv u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .valid    (v_reg[6]),
        .dividend (num_reg),
        .divisor  (b4_reg),
        .side     (side_in),
        .q_valid  (q_valid),
        .quotient (quotient),
        .q_side   (q_side)
    );

    // When B7 had its top bit set the doubling comes after the division.
    assign p_u = q_side[33] ? {quotient[30:0], 1'b0} : quotient;

    always_comb
    begin
        x1p = bpc_pkg::sdiv_pow2(m3038_reg, 16);
        pf  = p11_reg + bpc_pkg::sdiv_pow2(x1p + x2p11_reg + 32'sd3791, 4);
    end

    always_ff @(posedge clk)
    begin
        // Stage 8
        p8_reg    <= $signed(p_u);
        t8_reg    <= $signed(q_side[31:0]);
        f8_reg    <= q_side[32];
        // Stage 9
        pd_reg    <= bpc_pkg::sdiv_pow2(p8_reg, 8);
        m7357_reg <= p8_reg * -32'sd7357;
        p9_reg    <= p8_reg;
        t9_reg    <= t8_reg;
        f9_reg    <= f8_reg;
        // Stage 10
        pdsq_reg  <= pd_reg * pd_reg;
        x2p_reg   <= bpc_pkg::sdiv_pow2(m7357_reg, 16);
        p10_reg   <= p9_reg;
        t10_reg   <= t9_reg;
        f10_reg   <= f9_reg;
        // Stage 11
        m3038_reg <= pdsq_reg * 32'sd3038;
        x2p11_reg <= x2p_reg;
        p11_reg   <= p10_reg;
        t11_reg   <= t10_reg;
        f11_reg   <= f10_reg;
        // Stage 12
        res_reg.temp_tenths <= f11_reg ? 32'sd0 : t11_reg;
        res_reg.press_pa    <= f11_reg ? 32'sd0 : pf;
        res_reg.div_fault   <= f11_reg;
    end

    assign res_valid = v12_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire

// ----- sv/barometric_pressure_compensation.sv -----
// ----------------------------------------------------------------------------
// barometric_pressure_compensation
// Calibrated temperature and pressure from raw barometer readings.
// ----------------------------------------------------------------------------
// The block accepts one request per clock (busy is always low) and returns
// each result on the result port with done high for one cycle. Most of the
// pipeline depth lies in the two pipelined 32-stage dividers, one for X2 and
// one for the pressure quotient. Results cannot be held off. Calibration words
// must be written while no request is in flight.
`default_nettype none

module barometric_pressure_compensation (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    output logic                busy,
    input  wire bpc_pkg::req_t  request,
    output logic                done,
    output bpc_pkg::res_t       result,
    input  wire logic           cfg_we,
    input  wire logic [2:0]     cfg_index,
    input  wire logic [31:0]    cfg_data
);

    localparam int LAT = bpc_pkg::TEMP_LAT + bpc_pkg::PRESS_LAT;

    bpc_pkg::cal_t      cal_reg;
    logic               b5_valid, fault;
    logic signed [31:0] b5;
    logic [15:0]        up;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (bpc_pkg::reg_idx_t'(cfg_index))
                bpc_pkg::REG_CAL_A: cal_reg.cal_word_a <= cfg_data;
                bpc_pkg::REG_CAL_B: cal_reg.cal_word_b <= cfg_data;
                bpc_pkg::REG_CAL_C: cal_reg.cal_word_c <= cfg_data;
                bpc_pkg::REG_CAL_D: cal_reg.cal_word_d <= cfg_data;
                bpc_pkg::REG_CAL_E: cal_reg.cal_word_e <= cfg_data;
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    bpc_temp u_temp (
        .clk      (clk),
        .rst_n    (rst_n),
        .valid    (start & ~busy),
        .request  (request),
        .cal      (cal_reg),
        .b5_valid (b5_valid),
        .b5       (b5),
        .up       (up),
        .fault    (fault)
    );

    bpc_press u_press (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid     (b5_valid),
        .b5        (b5),
        .up        (up),
        .fault     (fault),
        .cal       (cal_reg),
        .res_valid (done),
        .res       (result)
    );

`ifndef SYNTHESIS
    a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.div_fault) |-> (result.temp_tenths == 32'sd0 &&
                                        result.press_pa == 32'sd0))
        else $error("fault result carries nonzero data");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LAT))
        else $error("result without a request at the pipeline latency");

    a_temp_stage: assert property (@(posedge clk) disable iff (!rst_n)
        b5_valid |-> $past(start, bpc_pkg::TEMP_LAT))
        else $error("temperature stage output without a matching request");
`endif

endmodule

`default_nettype wire

// ----- verif/barometric_pressure_compensation_tb.sv -----
// ----------------------------------------------------------------------------
// barometric_pressure_compensation_tb
// Self-checking bench for the barometer compensation pipeline.
// ----------------------------------------------------------------------------
// Requests are queued by the stimulus process and fed by a clocked driver with
// random idle bursts. A clocked monitor compares every result against readings
// computed by a local model of the calibration formulas. Calibration sets are
// changed only once the pipeline has drained.
`default_nettype none

module barometric_pressure_compensation_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PIPE_DEPTH = bpc_pkg::TEMP_LAT + bpc_pkg::PRESS_LAT;
    localparam int WATCHDOG   = 2000;

    logic           clk;
    logic           rst_n;
    logic           start;
    logic           busy;
    bpc_pkg::req_t  request;
    logic           done;
    bpc_pkg::res_t  result;
    logic           cfg_we;
    logic [2:0]     cfg_index;
    logic [31:0]    cfg_data;

    logic [31:0]    cal_words [5];
    bpc_pkg::req_t  pending_reqs [$];
    bpc_pkg::res_t  expected_readings [$];
    int             mismatches;
    int             idle_left;
    bit             idle_enable;
    int             quiet_cycles;
    bit             stim_done;

    barometric_pressure_compensation dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    function automatic logic signed [31:0] tdiv(input logic signed [31:0] a,
                                                input logic signed [31:0] d);
        if (d == -32'sd1)
            return -a;
        return a / d;
    endfunction

    function automatic logic signed [31:0] hi16(input logic [31:0] w);
        return {{16{w[31]}}, w[31:16]};
    endfunction

    function automatic logic signed [31:0] lo16(input logic [31:0] w);
        return {{16{w[15]}}, w[15:0]};
    endfunction

    function automatic bpc_pkg::res_t compensate(input bpc_pkg::req_t rq);
        logic signed [31:0] ac1, ac2, ac3, ac5, ac6, b1, b2, mc, md, ut;
        logic signed [31:0] x1, x2, x3, b3, b5, b6, t, p, sq, den;
        logic [31:0]        ac4, up, b4, b7;
        bpc_pkg::res_t      r;
        ac1 = hi16(cal_words[bpc_pkg::REG_CAL_A]);
        ac2 = lo16(cal_words[bpc_pkg::REG_CAL_A]);
        ac3 = hi16(cal_words[bpc_pkg::REG_CAL_B]);
        ac4 = {16'd0, cal_words[bpc_pkg::REG_CAL_B][15:0]};
        ac5 = {16'd0, cal_words[bpc_pkg::REG_CAL_C][31:16]};
        ac6 = {16'd0, cal_words[bpc_pkg::REG_CAL_C][15:0]};
        b1  = hi16(cal_words[bpc_pkg::REG_CAL_D]);
        b2  = lo16(cal_words[bpc_pkg::REG_CAL_D]);
        mc  = hi16(cal_words[bpc_pkg::REG_CAL_E]);
        md  = lo16(cal_words[bpc_pkg::REG_CAL_E]);
        ut  = {16'd0, rq.raw_temp};
        up  = {16'd0, rq.raw_press};
        r = '0;
        r.div_fault = 1'b1;
        x1  = tdiv((ut - ac6) * ac5, 32768);
        den = x1 + md;
        if (den == 0)
            return r;
        x2 = tdiv(mc * 2048, den);
        b5 = x1 + x2;
        t  = tdiv(b5 + 8, 16);
        b6 = b5 - 4000;
        sq = tdiv(b6 * b6, 4096);
        x1 = tdiv(b2 * sq, 2048);
        x2 = tdiv(ac2 * b6, 2048);
        x3 = x1 + x2;
        b3 = tdiv(ac1 * 4 + x3 + 2, 4);
        x1 = tdiv(ac3 * b6, 8192);
        x2 = tdiv(b1 * sq, 65536);
        x3 = tdiv(x1 + x2 + 2, 4);
        b4 = (ac4 * (x3 + 32'd32768)) / 32'd32768;
        if (b4 == 0)
            return r;
        b7 = (up - b3) * 32'd50000;
        if (b7 < 32'h8000_0000)
            p = (b7 * 2) / b4;
        else
            p = (b7 / b4) * 2;
        x1 = tdiv(p, 256) * tdiv(p, 256);
        x1 = tdiv(x1 * 3038, 65536);
        x2 = tdiv(-32'sd7357 * p, 65536);
        p  = p + tdiv(x1 + x2 + 3791, 16);
        r.temp_tenths = t;
        r.press_pa    = p;
        r.div_fault   = 1'b0;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %h expected %h", what, got, want);
        mismatches++;
    endtask

    // Driver: a request is taken at each edge where start is high.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start     <= 1'b0;
            request   <= '0;
            idle_left <= 0;
        end
        else
        begin
            if (start && !busy)
                expected_readings.push_back(compensate(request));
            if (start && busy)
            begin
                // Hold the current request.
            end
            else if (idle_left > 0)
            begin
                start     <= 1'b0;
                idle_left <= idle_left - 1;
            end
            else if (pending_reqs.size() > 0)
            begin
                start   <= 1'b1;
                request <= pending_reqs.pop_front();
                if (idle_enable && $urandom_range(0, 5) == 0)
                    idle_left <= $urandom_range(1, 17);
            end
            else
                start <= 1'b0;
        end
    end

    // Monitor.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_readings.size() == 0)
            begin
                report_mismatch("unexpected result", result.press_pa, 32'd0);
            end
            else
            begin
                bpc_pkg::res_t want;
                want = expected_readings.pop_front();
                if (result.temp_tenths !== want.temp_tenths)
                    report_mismatch("temp_tenths", result.temp_tenths, want.temp_tenths);
                if (result.press_pa !== want.press_pa)
                    report_mismatch("press_pa", result.press_pa, want.press_pa);
                if (result.div_fault !== want.div_fault)
                    report_mismatch("div_fault", 32'(result.div_fault),
                                    32'(want.div_fault));
            end
        end
    end

    // Watchdog on cycles without any accepted request or result.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || stim_done)
            quiet_cycles <= 0;
        else if (pending_reqs.size() > 0 || expected_readings.size() > 0)
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    task automatic write_cal(input bpc_pkg::reg_idx_t idx, input logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cal_words[idx] = value;
    endtask

    task automatic drain();
        while (pending_reqs.size() > 0 || start || expected_readings.size() > 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 4) @(posedge clk);
    endtask

    task automatic queue_req(input logic [15:0] t, input logic [15:0] p);
        bpc_pkg::req_t rq;
        rq.raw_temp  = t;
        rq.raw_press = p;
        pending_reqs.push_back(rq);
    endtask

    // Calibration words close to the datasheet example, with random jitter.
    task automatic load_typical();
        write_cal(bpc_pkg::REG_CAL_A, {16'd408 + 16'($urandom_range(0, 200)) - 16'd100,
                              -16'sd72 + 16'($urandom_range(0, 40)) - 16'sd20});
        write_cal(bpc_pkg::REG_CAL_B, {-16'sd14383 + 16'($urandom_range(0, 400)),
                              16'd32741 + 16'($urandom_range(0, 400))});
        write_cal(bpc_pkg::REG_CAL_C, {16'd32757 + 16'($urandom_range(0, 100)),
                              16'd23153 + 16'($urandom_range(0, 400))});
        write_cal(bpc_pkg::REG_CAL_D, {16'd6190, 16'd4});
        write_cal(bpc_pkg::REG_CAL_E, {-16'sd8711 + 16'($urandom_range(0, 200)),
                              16'd2868 + 16'($urandom_range(0, 200))});
    endtask

    initial
    begin
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        mismatches  = 0;
        idle_enable = 1'b1;
        stim_done   = 1'b0;
        foreach (cal_words[i])
            cal_words[i] = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // All-zero calibration: every request hits the zero divisor.
        queue_req(16'h0000, 16'h0000);
        queue_req(16'hffff, 16'hffff);
        drain();

        // Extreme calibration words.
        write_cal(bpc_pkg::REG_CAL_A, 32'hffff_ffff);
        write_cal(bpc_pkg::REG_CAL_B, 32'hffff_ffff);
        write_cal(bpc_pkg::REG_CAL_C, 32'hffff_ffff);
        write_cal(bpc_pkg::REG_CAL_D, 32'hffff_ffff);
        write_cal(bpc_pkg::REG_CAL_E, 32'hffff_ffff);
        queue_req(16'h0000, 16'h0000);
        queue_req(16'hffff, 16'hffff);
        queue_req(16'h8000, 16'h7fff);
        drain();
        write_cal(bpc_pkg::REG_CAL_A, 32'h7fff_8000);
        write_cal(bpc_pkg::REG_CAL_B, 32'h8000_ffff);
        write_cal(bpc_pkg::REG_CAL_C, 32'hffff_0000);
        write_cal(bpc_pkg::REG_CAL_D, 32'h7fff_7fff);
        write_cal(bpc_pkg::REG_CAL_E, 32'h8000_8000);
        queue_req(16'h0000, 16'hffff);
        queue_req(16'hffff, 16'h0000);
        queue_req(16'h5555, 16'haaaa);
        drain();

        // Datasheet-like set; MD chosen so X1 + MD hits zero for raw_temp = AC6.
        write_cal(bpc_pkg::REG_CAL_A, {16'd408, -16'sd72});
        write_cal(bpc_pkg::REG_CAL_B, {-16'sd14383, 16'd32741});
        write_cal(bpc_pkg::REG_CAL_C, {16'd32757, 16'd23153});
        write_cal(bpc_pkg::REG_CAL_D, {16'd6190, 16'd4});
        write_cal(bpc_pkg::REG_CAL_E, {-16'sd8711, 16'd0});
        queue_req(16'd23153, 16'd23843);
        drain();
        write_cal(bpc_pkg::REG_CAL_E, {-16'sd8711, 16'd2868});
        queue_req(16'd27898, 16'd23843);
        queue_req(16'd27898, 16'hffff);
        queue_req(16'd27898, 16'h0000);
        queue_req(16'h0000, 16'd23843);
        queue_req(16'hffff, 16'd23843);
        drain();
        // AC4 zero forces B4 to zero.
        write_cal(bpc_pkg::REG_CAL_B, {-16'sd14383, 16'd0});
        queue_req(16'd27898, 16'd23843);
        drain();

        // Random phases: typical sets most of the time, fully random sometimes.
        for (int ph = 0; ph < 8; ph++)
        begin
            if (ph % 3 == 2)
            begin
                write_cal(bpc_pkg::REG_CAL_A, $urandom);
                write_cal(bpc_pkg::REG_CAL_B, $urandom);
                write_cal(bpc_pkg::REG_CAL_C, $urandom);
                write_cal(bpc_pkg::REG_CAL_D, $urandom);
                write_cal(bpc_pkg::REG_CAL_E, $urandom);
            end
            else
                load_typical();
            idle_enable = (ph < 6);
            for (int n = 0; n < 50; n++)
            begin
                if ($urandom_range(0, 3) != 0)
                    queue_req(16'($urandom_range(20000, 36000)),
                              16'($urandom_range(15000, 45000)));
                else
                    queue_req(16'($urandom), 16'($urandom));
            end
            drain();
        end

        stim_done = 1'b1;
        if (mismatches == 0 && expected_readings.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire
